// ===== hdl/image_palette_indexer_unit_macros.svh =====
// Assertion macros used by the palette indexer RTL
`ifndef IMAGE_PALETTE_INDEXER_UNIT_MACROS_SVH
`define IMAGE_PALETTE_INDEXER_UNIT_MACROS_SVH

// same-cycle implication, held off during reset
`define IPI_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define IPI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/ipi_pkg.sv =====
// Types and constants of the palette indexer
`default_nettype none
package ipi_pkg;
   localparam int CNT_W  = 9;
   localparam int BPP_W  = 3;
   localparam int DIM_W  = 9;
   localparam int PIX_W  = 32;
   localparam int CSR_IW = 2;

   localparam logic [1:0] KIND_PAL  = 2'd0;
   localparam logic [1:0] KIND_IDX  = 2'd1;
   localparam logic [1:0] KIND_RAW  = 2'd2;
   localparam logic [1:0] KIND_NONE = 2'd3;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_PULL = 1'b1;

   localparam logic [CSR_IW-1:0] REG_BPP    = 2'd0;
   localparam logic [CSR_IW-1:0] REG_WIDTH  = 2'd1;
   localparam logic [CSR_IW-1:0] REG_HEIGHT = 2'd2;

   typedef enum logic [1:0] {
      PH_LOADING,
      PH_EMITTING
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH,
      ST_SRCH_CMP,
      ST_SHIFT,
      ST_SHIFT_WR,
      ST_LD_FIN,
      ST_PL_COL,
      ST_PL_PIX,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [BPP_W-1:0] bpp;
      logic [PIX_W-1:0] pix_mask;
   } geom_type;
endpackage
`default_nettype wire

// ===== hdl/ipi_geom.sv =====
// Configuration registers and derived image geometry
`default_nettype none
module ipi_geom #(
   parameter int MAX_PIXELS = 65536
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic [ipi_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [ipi_pkg::DIM_W-1:0]  csr_wdata,
   output ipi_pkg::geom_type               geom,
   output logic [$clog2(MAX_PIXELS+1)-1:0] npix
);
   localparam int NPIX_W = $clog2(MAX_PIXELS + 1);
   localparam int PROD_W = 2 * ipi_pkg::DIM_W;
   localparam int CMP_W  = ((NPIX_W > PROD_W) ? NPIX_W : PROD_W) + 1;

   logic [ipi_pkg::BPP_W-1:0] bpp_ff;
   logic [ipi_pkg::DIM_W-1:0] width_ff;
   logic [ipi_pkg::DIM_W-1:0] height_ff;
   logic [ipi_pkg::DIM_W-1:0] w_eff, h_eff;
   logic [PROD_W-1:0]         prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= ipi_pkg::BPP_W'(4);
         width_ff  <= ipi_pkg::DIM_W'(256);
         height_ff <= ipi_pkg::DIM_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            ipi_pkg::REG_BPP:    bpp_ff    <= csr_wdata[ipi_pkg::BPP_W-1:0];
            ipi_pkg::REG_WIDTH:  width_ff  <= csr_wdata;
            ipi_pkg::REG_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   function automatic logic [ipi_pkg::DIM_W-1:0] clamp_dim(logic [ipi_pkg::DIM_W-1:0] d);
      logic [ipi_pkg::DIM_W-1:0] r;
      r = d;
      if (d == '0) r = ipi_pkg::DIM_W'(1);
      else if (d > ipi_pkg::DIM_W'(256)) r = ipi_pkg::DIM_W'(256);
      return r;
   endfunction

   always_comb begin
      w_eff = clamp_dim(width_ff);
      h_eff = clamp_dim(height_ff);
      prod  = PROD_W'(w_eff) * PROD_W'(h_eff);
      if (CMP_W'(prod) > CMP_W'(MAX_PIXELS)) npix = NPIX_W'(MAX_PIXELS);
      else npix = NPIX_W'(prod);

      case (bpp_ff)
         3'd0, 3'd1: begin
            geom.bpp      = 3'd1;
            geom.pix_mask = 32'h0000_00FF;
         end
         3'd2: begin
            geom.bpp      = 3'd2;
            geom.pix_mask = 32'h0000_FFFF;
         end
         3'd3: begin
            geom.bpp      = 3'd3;
            geom.pix_mask = 32'h00FF_FFFF;
         end
         default: begin
            geom.bpp      = 3'd4;
            geom.pix_mask = 32'hFFFF_FFFF;
         end
      endcase
   end
endmodule
`default_nettype wire

// ===== hdl/image_palette_indexer_unit.sv =====
// Palette indexer: loads an image, builds a sorted palette, then streams records
//
// Usage. The req channel (valid/ready) carries commands: req_cmd 0 loads the next
// pixel in raster order, req_cmd 1 pulls the next output record. Loads give no
// transaction on rsp; every pull gives exactly one rsp transaction. The csr port
// writes bytes_per_pixel (0), image_width (1) and image_height (2); write it only
// while no command is in flight.
// Once the last pixel is loaded the block picks palette or raw encoding. Pulls
// then return the palette in ascending order, then an index or raw value per
// pixel. A pull during loading returns kind 3 with zeroed fields.
// Work per command, around the single-port colour memory of MAX_COLORS entries:
//   load: a binary search over the colour set, then for a new colour an ordered
//         insert that moves entries up one at a time (up to MAX_COLORS-1 moves);
//         no search once the colour set has overflowed;
//   pull: one read for a palette entry or raw pixel; for an index, a pixel store
//         read, then the same binary search.
// The result sits in an output register; req is taken again while it waits, and
// a pull stalls only if the previous record is still not taken.
// Reset clears counts, phase and the response valid flag; memories are not cleared.
`default_nettype none
`include "image_palette_indexer_unit_macros.svh"
module image_palette_indexer_unit #(
   parameter int MAX_PIXELS = 65536,
   parameter int MAX_COLORS = 256
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_cmd,
   input  wire logic [31:0]                req_pixel_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_record_kind,
   output logic [31:0]                     rsp_record_value,
   output logic [8:0]                      rsp_palette_count,
   output logic                            rsp_is_last_record,
   input  wire logic                       csr_we,
   input  wire logic [ipi_pkg::CSR_IW-1:0] csr_index,
   input  wire logic [ipi_pkg::DIM_W-1:0]  csr_wdata
);
   localparam int CNT_W  = ipi_pkg::CNT_W;
   localparam int NPIX_W = $clog2(MAX_PIXELS + 1);
   localparam int PA_W   = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
   localparam int CA_W   = $clog2(MAX_COLORS);
   localparam int EPOS_W = $clog2(MAX_PIXELS + MAX_COLORS + 1);
   localparam int EW0    = (EPOS_W > CNT_W) ? EPOS_W : CNT_W;
   localparam int EW     = ((EW0 > NPIX_W) ? EW0 : NPIX_W) + 1;
   localparam int DEC_W  = ((NPIX_W > CNT_W) ? NPIX_W : CNT_W) + 4;

   ipi_pkg::geom_type     geom;
   logic [NPIX_W-1:0]     npix;

   ipi_geom #(.MAX_PIXELS(MAX_PIXELS)) u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .geom      (geom),
      .npix      (npix)
   );

   // memories
   logic [31:0] pix_mem [MAX_PIXELS];
   logic [31:0] col_mem [MAX_COLORS];
   logic        pix_we;
   logic [PA_W-1:0] pix_ra;
   logic [31:0] pix_rdata_ff;
   logic        col_we;
   logic [CA_W-1:0] col_addr;
   logic [31:0] col_wd;
   logic [31:0] col_rdata_ff;

   // control and datapath state
   ipi_pkg::state_type state_ff, state_in;
   ipi_pkg::phase_type phase_ff, phase_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [NPIX_W-1:0] lpos_ff, lpos_in;
   logic [EPOS_W-1:0] epos_ff, epos_in;
   logic [CNT_W-1:0]  lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in, sh_ff, sh_in;
   logic [31:0]       key_ff, key_in;
   logic              hit_ff, hit_in;
   logic              pull_ff, pull_in;
   logic [1:0]        res_kind_ff, res_kind_in;
   logic [31:0]       res_value_ff, res_value_in;
   logic              res_last_ff, res_last_in;
   logic              res_commit_ff, res_commit_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [31:0]       rsp_value_ff, rsp_value_in;
   logic [8:0]        rsp_count_ff, rsp_count_in;
   logic              rsp_last_ff, rsp_last_in;

   logic [EW-1:0]     epos_x, cnt_x, npix_x;
   logic [CNT_W:0]    mid_sum;
   logic [CNT_W-1:0]  idx;
   logic [DEC_W-1:0]  with_pal, raw;

   always_ff @(posedge clock) begin
      if (pix_we) pix_mem[lpos_ff[PA_W-1:0]] <= req_pixel_value & geom.pix_mask;
      pix_rdata_ff <= pix_mem[pix_ra];
   end

   always_ff @(posedge clock) begin
      if (col_we) col_mem[col_addr] <= col_wd;
      else col_rdata_ff <= col_mem[col_addr];
   end

   always_comb begin
      epos_x  = EW'(epos_ff);
      cnt_x   = EW'(count_ff);
      npix_x  = EW'(npix);
      mid_sum = {1'b0, lo_ff} + {1'b0, hi_ff};
      idx     = (lo_ff >= count_ff) ? (count_ff - CNT_W'(1)) : lo_ff;
      with_pal = DEC_W'(npix) + DEC_W'(count_ff) * DEC_W'(geom.bpp);
      raw      = DEC_W'(npix) * DEC_W'(geom.bpp);
      pix_ra   = PA_W'(epos_x - cnt_x);
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      lpos_in  = lpos_ff;
      epos_in  = epos_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      sh_in    = sh_ff;
      key_in   = key_ff;
      hit_in   = hit_ff;
      pull_in  = pull_ff;
      res_kind_in   = res_kind_ff;
      res_value_in  = res_value_ff;
      res_last_in   = res_last_ff;
      res_commit_in = res_commit_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      req_ready = 1'b0;
      pix_we    = 1'b0;
      col_we    = 1'b0;
      col_addr  = mid_ff[CA_W-1:0];
      col_wd    = key_ff;

      case (state_ff)
         ipi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == ipi_pkg::CMD_LOAD) begin
                  if (phase_ff == ipi_pkg::PH_LOADING) begin
                     state_in = ipi_pkg::ST_LD_FIN;
                     if (lpos_ff < npix) begin
                        pix_we  = 1'b1;
                        lpos_in = lpos_ff + NPIX_W'(1);
                        if (!ovf_ff) begin
                           key_in   = req_pixel_value & geom.pix_mask;
                           lo_in    = '0;
                           hi_in    = count_ff;
                           hit_in   = 1'b0;
                           pull_in  = 1'b0;
                           state_in = ipi_pkg::ST_SRCH;
                        end
                     end
                  end
               end else if (phase_ff != ipi_pkg::PH_EMITTING) begin
                  res_kind_in   = ipi_pkg::KIND_NONE;
                  res_value_in  = '0;
                  res_last_in   = 1'b0;
                  res_commit_in = 1'b0;
                  state_in      = ipi_pkg::ST_RESP;
               end else begin
                  res_last_in   = (epos_x + EW'(1)) >= (cnt_x + npix_x);
                  res_commit_in = 1'b1;
                  if (epos_x < cnt_x) begin
                     col_addr = epos_ff[CA_W-1:0];
                     state_in = ipi_pkg::ST_PL_COL;
                  end else begin
                     state_in = ipi_pkg::ST_PL_PIX;
                  end
               end
            end
         end
         ipi_pkg::ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               mid_in   = mid_sum[CNT_W:1];
               col_addr = mid_sum[CA_W:1];
               state_in = ipi_pkg::ST_SRCH_CMP;
            end else if (pull_ff) begin
               res_kind_in  = ipi_pkg::KIND_IDX;
               res_value_in = {24'd0, idx[7:0]};
               state_in     = ipi_pkg::ST_RESP;
            end else if (hit_ff) begin
               state_in = ipi_pkg::ST_LD_FIN;
            end else if (count_ff >= CNT_W'(MAX_COLORS)) begin
               ovf_in   = 1'b1;
               state_in = ipi_pkg::ST_LD_FIN;
            end else begin
               sh_in    = count_ff;
               state_in = ipi_pkg::ST_SHIFT;
            end
         end
         ipi_pkg::ST_SRCH_CMP: begin
            if (col_rdata_ff < key_ff) begin
               lo_in = mid_ff + CNT_W'(1);
            end else begin
               hi_in  = mid_ff;
               hit_in = (col_rdata_ff == key_ff);
            end
            state_in = ipi_pkg::ST_SRCH;
         end
         ipi_pkg::ST_SHIFT: begin
            if (sh_ff > lo_ff) begin
               col_addr = CA_W'(sh_ff - CNT_W'(1));
               state_in = ipi_pkg::ST_SHIFT_WR;
            end else begin
               col_we   = 1'b1;
               col_addr = lo_ff[CA_W-1:0];
               count_in = count_ff + CNT_W'(1);
               state_in = ipi_pkg::ST_LD_FIN;
            end
         end
         ipi_pkg::ST_SHIFT_WR: begin
            // move one entry up to open the insertion slot
            col_we   = 1'b1;
            col_addr = sh_ff[CA_W-1:0];
            col_wd   = col_rdata_ff;
            sh_in    = sh_ff - CNT_W'(1);
            state_in = ipi_pkg::ST_SHIFT;
         end
         ipi_pkg::ST_LD_FIN: begin
            if (lpos_ff >= npix) begin
               if (ovf_ff || !(with_pal < raw)) count_in = '0;
               epos_in  = '0;
               phase_in = ipi_pkg::PH_EMITTING;
            end
            state_in = ipi_pkg::ST_IDLE;
         end
         ipi_pkg::ST_PL_COL: begin
            res_kind_in  = ipi_pkg::KIND_PAL;
            res_value_in = col_rdata_ff;
            state_in     = ipi_pkg::ST_RESP;
         end
         ipi_pkg::ST_PL_PIX: begin
            if (count_ff != '0) begin
               key_in   = pix_rdata_ff;
               lo_in    = '0;
               hi_in    = count_ff;
               hit_in   = 1'b0;
               pull_in  = 1'b1;
               state_in = ipi_pkg::ST_SRCH;
            end else begin
               res_kind_in  = ipi_pkg::KIND_RAW;
               res_value_in = pix_rdata_ff;
               state_in     = ipi_pkg::ST_RESP;
            end
         end
         ipi_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = res_kind_ff;
               rsp_value_in = res_value_ff;
               rsp_count_in = (res_kind_ff == ipi_pkg::KIND_NONE) ? 9'd0 : count_ff;
               rsp_last_in  = res_last_ff;
               if (res_commit_ff) begin
                  if (res_last_ff) begin
                     count_in = '0;
                     ovf_in   = 1'b0;
                     lpos_in  = '0;
                     epos_in  = '0;
                     phase_in = ipi_pkg::PH_LOADING;
                  end else begin
                     epos_in = epos_ff + EPOS_W'(1);
                  end
               end
               state_in = ipi_pkg::ST_IDLE;
            end
         end
         default: state_in = ipi_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ipi_pkg::ST_IDLE;
         phase_ff     <= ipi_pkg::PH_LOADING;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         lpos_ff      <= '0;
         epos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         lpos_ff      <= lpos_in;
         epos_ff      <= epos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      sh_ff         <= sh_in;
      key_ff        <= key_in;
      hit_ff        <= hit_in;
      pull_ff       <= pull_in;
      res_kind_ff   <= res_kind_in;
      res_value_ff  <= res_value_in;
      res_last_ff   <= res_last_in;
      res_commit_ff <= res_commit_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_kind    = rsp_kind_ff;
   assign rsp_record_value   = rsp_value_ff;
   assign rsp_palette_count  = rsp_count_ff;
   assign rsp_is_last_record = rsp_last_ff;

   `IPI_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_COLORS), "colour count beyond capacity")
   `IPI_ASSERT_NOW(a_mid_in_set, clock, reset, state_ff == ipi_pkg::ST_SRCH_CMP, mid_ff < count_ff, "search probe outside colour set")
   `IPI_ASSERT_NOW(a_ovf_raw, clock, reset, phase_ff == ipi_pkg::PH_EMITTING && ovf_ff, count_ff == '0, "overflowed image not raw")
   `IPI_ASSERT_NOW(a_rsp_from_resp, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ipi_pkg::ST_RESP, "response raised outside response state")
endmodule
`default_nettype wire

// ===== test/tb_image_palette_indexer_unit.sv =====
// Self-checking testbench for the palette indexer: random images, live prediction, record checks
`default_nettype none
module tb_image_palette_indexer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 700;   // a load may still be inserting into a full colour set

   typedef struct {
      logic        cmd;
      logic [31:0] pix;
   } cmd_item_type;

   typedef struct {
      logic [1:0]  kind;
      logic [31:0] value;
      logic [8:0]  count;
      logic        last;
   } record_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_cmd = ipi_pkg::CMD_LOAD;
   logic [31:0] req_pixel_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_record_kind;
   logic [31:0] rsp_record_value;
   logic [8:0]  rsp_palette_count;
   logic        rsp_is_last_record;
   logic        csr_we = 1'b0;
   logic [ipi_pkg::CSR_IW-1:0] csr_index = ipi_pkg::REG_BPP;
   logic [ipi_pkg::DIM_W-1:0]  csr_wdata = '0;

   image_palette_indexer_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_cmd(req_cmd), .req_pixel_value(req_pixel_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_record_kind(rsp_record_kind), .rsp_record_value(rsp_record_value),
      .rsp_palette_count(rsp_palette_count), .rsp_is_last_record(rsp_is_last_record),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // register mirror
   logic [2:0] cfg_bpp = 3'd4;
   logic [8:0] cfg_width = 9'd256;
   logic [8:0] cfg_height = 9'd256;

   // predicted block state
   logic [31:0] pixel_mem [65536];
   logic [31:0] palette_q[$];
   bit          colours_overflowed;
   int unsigned load_pos, emit_pos;
   ipi_pkg::phase_type img_phase = ipi_pkg::PH_LOADING;

   cmd_item_type cmd_q[$];
   record_type   record_q[$];
   int          errors = 0;
   int          records_checked = 0;
   int          images_sent = 0;
   int          items_sent = 0;

   function automatic int unsigned eff_bpp();
      if (cfg_bpp == 0) return 1;
      if (cfg_bpp > 4) return 4;
      return cfg_bpp;
   endfunction

   function automatic int unsigned clamp_dim(logic [8:0] d);
      if (d == 0) return 1;
      if (d > 256) return 256;
      return d;
   endfunction

   function automatic int unsigned pixel_count();
      return clamp_dim(cfg_width) * clamp_dim(cfg_height);
   endfunction

   function automatic logic [31:0] mask_colour(logic [31:0] v);
      int unsigned b;
      b = eff_bpp();
      if (b >= 4) return v;
      return v & ((32'd1 << (8 * b)) - 32'd1);
   endfunction

   function automatic int palette_lower_bound(logic [31:0] v);
      int lo, hi, mid;
      lo = 0;
      hi = palette_q.size();
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (palette_q[mid] < v) lo = mid + 1; else hi = mid;
      end
      return lo;
   endfunction

   function automatic void clear_image();
      palette_q.delete();
      colours_overflowed = 0;
      load_pos = 0;
      emit_pos = 0;
      img_phase = ipi_pkg::PH_LOADING;
   endfunction

   // advance the predicted state by one accepted transaction
   function automatic void predict_command(cmd_item_type it);
      int unsigned npix, b, cnt, total, p, pos;
      logic [31:0] v;
      int idx;
      record_type r;
      npix = pixel_count();
      if (it.cmd == ipi_pkg::CMD_LOAD) begin
         if (img_phase != ipi_pkg::PH_LOADING) return;
         if (load_pos < npix) begin
            v = mask_colour(it.pix);
            pixel_mem[load_pos] = v;
            if (!colours_overflowed) begin
               idx = palette_lower_bound(v);
               if (!(idx < palette_q.size() && palette_q[idx] == v)) begin
                  if (palette_q.size() >= 256) colours_overflowed = 1;
                  else palette_q.insert(idx, v);
               end
            end
            load_pos++;
         end
         if (load_pos >= npix) begin
            b = eff_bpp();
            if (colours_overflowed || !(longint'(npix) + longint'(palette_q.size()) * b
                                        < longint'(npix) * b))
               palette_q.delete();
            emit_pos = 0;
            img_phase = ipi_pkg::PH_EMITTING;
         end
         return;
      end
      if (img_phase != ipi_pkg::PH_EMITTING) begin
         r = '{ipi_pkg::KIND_NONE, 32'd0, 9'd0, 1'b0};
         record_q.push_back(r);
         return;
      end
      cnt = palette_q.size();
      total = cnt + npix;
      pos = emit_pos;
      if (pos < cnt) begin
         r.kind = ipi_pkg::KIND_PAL;
         r.value = palette_q[pos];
      end else begin
         p = pos - cnt;
         v = pixel_mem[p];
         if (cnt > 0) begin
            idx = palette_lower_bound(v);
            if (idx >= cnt) idx = cnt - 1;
            r.kind = ipi_pkg::KIND_IDX;
            r.value = idx & 32'hFF;
         end else begin
            r.kind = ipi_pkg::KIND_RAW;
            r.value = v;
         end
      end
      r.count = cnt[8:0];
      r.last = (pos + 1 >= total);
      record_q.push_back(r);
      if (pos + 1 >= total) clear_image();
      else emit_pos = pos + 1;
   endfunction

   initial begin
      forever #5 clock = ~clock;
   end

   // sender: bursts of random length, random gaps between them
   bit           req_taken = 0;
   int           burst_left = 0;
   int           gap_left = 0;
   cmd_item_type cur_item;

   always @(posedge clock) begin
      req_taken = 0;
      if (!reset && req_valid && req_ready) begin
         predict_command('{req_cmd, req_pixel_value});
         req_taken = 1;
      end
   end

   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            cur_item = cmd_q.pop_front();
            req_valid <= 1'b1;
            req_cmd <= cur_item.cmd;
            req_pixel_value <= cur_item.pix;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: randomly chosen stall pattern, plus one long hold-off
   bit          long_stall_req = 0;
   bit          long_stall_seen = 0;
   int          stall_left = 0;
   int unsigned rx_cycle = 0;
   logic [1:0]  rx_mode = 2'd0;

   always @(negedge clock) begin
      rx_cycle++;
      if (rx_cycle % 64 == 0) rx_mode = 2'($urandom_range(0, 3));
      if (long_stall_req && !long_stall_seen && rsp_valid) begin
         stall_left = 400;
         long_stall_seen = 1;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (rx_mode)
            2'd0, 2'd3: rsp_ready <= 1'b1;
            2'd1: rsp_ready <= 1'($urandom_range(0, 1));
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      record_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (record_q.size() == 0) begin
            $display("%0t: unexpected record: kind %0d value %h count %0d last %0d",
                     $time, rsp_record_kind, rsp_record_value, rsp_palette_count,
                     rsp_is_last_record);
            errors++;
         end else begin
            e = record_q.pop_front();
            records_checked++;
            if (rsp_record_kind !== e.kind) begin
               $display("%0t: record_kind expected %0d actual %0d", $time, e.kind,
                        rsp_record_kind);
               errors++;
            end
            if (rsp_record_value !== e.value) begin
               $display("%0t: record_value expected %h actual %h", $time, e.value,
                        rsp_record_value);
               errors++;
            end
            if (rsp_palette_count !== e.count) begin
               $display("%0t: palette_count expected %0d actual %0d", $time, e.count,
                        rsp_palette_count);
               errors++;
            end
            if (rsp_is_last_record !== e.last) begin
               $display("%0t: is_last_record expected %0d actual %0d", $time, e.last,
                        rsp_is_last_record);
               errors++;
            end
         end
      end
   end

   task automatic wait_idle();
      while (cmd_q.size() > 0 || req_valid || record_q.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [ipi_pkg::CSR_IW-1:0] idx, logic [8:0] data);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         ipi_pkg::REG_BPP: cfg_bpp = data[2:0];
         ipi_pkg::REG_WIDTH: cfg_width = data;
         default: cfg_height = data;
      endcase
   endtask

   task automatic set_geometry(logic [8:0] bpp, logic [8:0] w, logic [8:0] h);
      wait_idle();
      write_csr(ipi_pkg::REG_BPP, bpp);
      write_csr(ipi_pkg::REG_WIDTH, w);
      write_csr(ipi_pkg::REG_HEIGHT, h);
   endtask

   // queue one whole image: loads, then exactly enough pulls to drain it
   task automatic queue_image(int unsigned ncol, bit noisy);
      logic [31:0] colours[$];
      bit          seen[logic [31:0]];
      int unsigned npix, b, c, pulls;
      logic [31:0] v;
      npix = pixel_count();
      b = eff_bpp();
      for (int i = 0; i < ncol; i++) colours.push_back($urandom());
      for (int i = 0; i < npix; i++) begin
         if (noisy && $urandom_range(0, 7) == 0) begin
            cmd_q.push_back('{ipi_pkg::CMD_PULL, $urandom()});
            items_sent++;
         end
         v = colours[$urandom_range(0, ncol - 1)];
         seen[mask_colour(v)] = 1;
         cmd_q.push_back('{ipi_pkg::CMD_LOAD, v});
         items_sent++;
      end
      c = seen.num();
      pulls = npix;
      if (c <= 256 && npix + c * b < npix * b) pulls += c;
      for (int i = 0; i < pulls; i++) begin
         if (noisy && $urandom_range(0, 9) == 0) begin
            cmd_q.push_back('{ipi_pkg::CMD_LOAD, $urandom()});
            items_sent++;
         end
         cmd_q.push_back('{ipi_pkg::CMD_PULL, $urandom()});
         items_sent++;
      end
      images_sent++;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: pull while loading, all-ones/all-zero pixels, zero and oversize registers
      cmd_q.push_back('{ipi_pkg::CMD_PULL, 32'hFFFF_FFFF});
      items_sent++;
      set_geometry(9'd4, 9'd2, 9'd2);
      cmd_q.push_back('{ipi_pkg::CMD_LOAD, 32'hFFFF_FFFF});
      cmd_q.push_back('{ipi_pkg::CMD_LOAD, 32'h0000_0000});
      cmd_q.push_back('{ipi_pkg::CMD_LOAD, 32'hFFFF_FFFF});
      cmd_q.push_back('{ipi_pkg::CMD_LOAD, 32'h0000_0000});
      cmd_q.push_back('{ipi_pkg::CMD_LOAD, 32'h1234_5678});   // ignored while emitting
      repeat (6) cmd_q.push_back('{ipi_pkg::CMD_PULL, 32'h0});
      items_sent += 11;
      set_geometry(9'd0, 9'd0, 9'd0);
      cmd_q.push_back('{ipi_pkg::CMD_LOAD, 32'hA5A5_A5FF});
      cmd_q.push_back('{ipi_pkg::CMD_PULL, 32'h0});
      cmd_q.push_back('{ipi_pkg::CMD_PULL, 32'h0});
      items_sent += 3;
      set_geometry(9'd7, 9'd3, 9'd1);
      queue_image(1, 0);
      set_geometry(9'd1, 9'd2, 9'd1);
      queue_image(2, 0);

      // extremes of the geometry, with a long receiver hold-off on the first
      set_geometry(9'd4, 9'd511, 9'd1);
      long_stall_req = 1;
      queue_image(5, 0);
      set_geometry(9'd3, 9'd1, 9'd16);
      queue_image(3, 1);
      // colour set overflow: nearly every pixel a new colour
      set_geometry(9'd4, 9'd20, 9'd13);
      queue_image(100000, 0);

      while (items_sent < 1100) begin
         if ($urandom_range(0, 1) == 0) begin
            set_geometry(9'($urandom_range(0, 7)),
                         ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 6)),
                         ($urandom_range(0, 15) == 0) ? 9'd0 : 9'($urandom_range(1, 6)));
         end
         queue_image($urandom_range(1, 4), $urandom_range(0, 3) == 0);
      end

      wait_idle();
      $display("Run covered %0d images, %0d commands, %0d records checked.",
               images_sent, items_sent, records_checked);
      if (errors == 0 && record_q.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("%0d mismatches, %0d records outstanding", errors, record_q.size());
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #30ms;
      $display("Timeout with %0d records outstanding", record_q.size());
      $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/ipi_pkg.sv
hdl/ipi_geom.sv
hdl/image_palette_indexer_unit.sv
test/tb_image_palette_indexer_unit.sv
